@@ rtl/wbrm_pkg.sv @@
// ----------------------------------------------------------------------------
// wbrm_pkg
// Types and constants shared by the windowed byte rate meter modules.
// ----------------------------------------------------------------------------
package wbrm_pkg;

  // field widths
  localparam int DATA_W   = 64;
  localparam int COARSE_W = 48;
  localparam int COARSE_LSB = 16;
  localparam int FINE_W   = 6;
  localparam int WIN_W    = 16;
  localparam int RATE_W   = 40;
  localparam int FTERM_W  = 9;

  // rate is bits per millisecond in Q.8: bytes * 8 * 256
  localparam int FRAC_SHIFT = 11;

  // register reset and limits
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 16'd2000;
  localparam logic [RATE_W-1:0] RATE_MAX     = {RATE_W{1'b1}};

  // ticks per millisecond scaling: ms = (ticks * 125 + fine) / 100
  localparam logic [7:0] MS_DIVISOR = 8'd100;

  // input transaction
  typedef struct packed {
    logic              meter_select;
    logic [DATA_W-1:0] byte_total;
    logic [DATA_W-1:0] raw_stamp;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic              rate_valid;
    logic [RATE_W-1:0] rate_kbps;
  } out_item_t;

  // status of the elapsed time unit
  typedef struct packed {
    logic done;
    logic total_ge;
  } ela_stat_t;

  // fine correction: (now - last) * 125 / 40, truncated toward zero
  function automatic logic signed [FTERM_W-1:0] fine_term(
    input logic [FINE_W-1:0] now_fine,
    input logic [FINE_W-1:0] last_fine
  );
    logic signed [FINE_W:0] dprec;
    logic [FINE_W-1:0]      mag;
    logic [10:0]            prod;
    logic [FTERM_W-1:0]     scaled;
    dprec  = $signed({1'b0, now_fine}) - $signed({1'b0, last_fine});
    mag    = dprec[FINE_W] ? FINE_W'(-dprec) : dprec[FINE_W-1:0];
    prod   = 11'(mag) * 11'd25;
    scaled = FTERM_W'(prod >> 3);
    return dprec[FINE_W] ? $signed(-scaled) : $signed(scaled);
  endfunction

endpackage

@@ rtl/wbrm_elapsed.sv @@
// ----------------------------------------------------------------------------
// wbrm_elapsed
// Bit-serial front end: byte delta, tick delta times 125 plus fine term,
// then a serial divide by 100 giving the elapsed milliseconds.
// ----------------------------------------------------------------------------
module wbrm_elapsed (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  logic [wbrm_pkg::DATA_W-1:0]                total,
  input  logic [wbrm_pkg::DATA_W-1:0]                last_total,
  input  logic [wbrm_pkg::COARSE_W-1:0]              coarse,
  input  logic [wbrm_pkg::COARSE_W-1:0]              last_coarse,
  input  logic signed [wbrm_pkg::FTERM_W-1:0]        fterm,
  output wbrm_pkg::ela_stat_t                        stat,
  output logic [wbrm_pkg::DATA_W-1:0]                delta,
  output logic [wbrm_pkg::DATA_W-1:0]                ms
);

  localparam int          DW       = wbrm_pkg::DATA_W;
  localparam int          CNT_W    = $clog2(DW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);
  localparam logic [1:0]  P_IDLE   = 2'd0;
  localparam logic [1:0]  P_SUB    = 2'd1;
  localparam logic [1:0]  P_DIV    = 2'd2;

  logic [1:0]       phase;
  logic [CNT_W-1:0] cnt;
  logic             done;

  logic [DW-1:0]    tot_a;
  logic [DW-1:0]    tot_b;
  logic [DW-1:0]    tim_a;
  logic [DW-1:0]    tim_b;
  logic             tot_brw;
  logic             tim_brw;
  logic signed [wbrm_pkg::FTERM_W-1:0] fterm_sh;
  logic [5:0]       hist;
  logic [2:0]       carry;
  logic [6:0]       rem;
  logic [DW-1:0]    sum_sh;
  logic [DW-1:0]    delta_sh;

  logic             d_tot;
  logic             tot_brw_next;
  logic             dt;
  logic             tim_brw_next;
  logic [3:0]       col;
  logic [7:0]       rem_sh;
  logic             q_bit;
  logic [6:0]       rem_next;

  // serial subtractors, lsb first
  assign d_tot        = tot_a[0] ^ tot_b[0] ^ tot_brw;
  assign tot_brw_next = (~tot_a[0] & tot_b[0]) | (~(tot_a[0] ^ tot_b[0]) & tot_brw);
  assign dt           = tim_a[0] ^ tim_b[0] ^ tim_brw;
  assign tim_brw_next = (~tim_a[0] & tim_b[0]) | (~(tim_a[0] ^ tim_b[0]) & tim_brw);

  // column of dt * 125 (taps 0, 2..6) plus sign-extended fine term
  assign col = 4'(dt) + 4'(hist[1]) + 4'(hist[2]) + 4'(hist[3]) + 4'(hist[4])
             + 4'(hist[5]) + 4'(fterm_sh[0]) + 4'(carry);

  // serial restoring divide by 100, msb first
  assign rem_sh   = {rem, sum_sh[DW-1]};
  assign q_bit    = (rem_sh >= wbrm_pkg::MS_DIVISOR);
  assign rem_next = q_bit ? 7'(rem_sh - wbrm_pkg::MS_DIVISOR) : rem_sh[6:0];

  // phase sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          cnt <= '0;
          if (start) begin
            phase <= P_SUB;
          end
        end
        P_SUB: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            phase <= P_DIV;
          end
        end
        P_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            phase <= P_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    if (phase == P_IDLE) begin
      if (start) begin
        tot_a    <= total;
        tot_b    <= last_total;
        tim_a    <= DW'(coarse);
        tim_b    <= DW'(last_coarse);
        fterm_sh <= fterm;
        tot_brw  <= 1'b0;
        tim_brw  <= 1'b0;
        hist     <= '0;
        carry    <= '0;
        rem      <= '0;
      end
    end else if (phase == P_SUB) begin
      tot_a    <= tot_a >> 1;
      tot_b    <= tot_b >> 1;
      tim_a    <= tim_a >> 1;
      tim_b    <= tim_b >> 1;
      tot_brw  <= tot_brw_next;
      tim_brw  <= tim_brw_next;
      fterm_sh <= fterm_sh >>> 1;
      hist     <= {hist[4:0], dt};
      carry    <= col[3:1];
      sum_sh   <= {col[0], sum_sh[DW-1:1]};
      delta_sh <= {d_tot, delta_sh[DW-1:1]};
    end else if (phase == P_DIV) begin
      rem    <= rem_next;
      sum_sh <= {sum_sh[DW-2:0], q_bit};
    end
  end

  assign stat.done     = done;
  assign stat.total_ge = ~tot_brw;
  assign delta         = delta_sh;
  assign ms            = sum_sh;

endmodule

@@ rtl/wbrm_divider.sv @@
// ----------------------------------------------------------------------------
// wbrm_divider
// Restoring divider, one quotient bit per cycle: (delta << 11) / ms,
// saturated to the 40-bit rate.
// ----------------------------------------------------------------------------
module wbrm_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [wbrm_pkg::DATA_W-1:0]       dividend,
  input  logic [wbrm_pkg::DATA_W-1:0]       divisor,
  output logic                              done,
  output logic [wbrm_pkg::RATE_W-1:0]       rate
);

  localparam int DW    = wbrm_pkg::DATA_W;
  localparam int RW    = wbrm_pkg::RATE_W;
  localparam int STEPS = DW + wbrm_pkg::FRAC_SHIFT;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);
  localparam logic [CNT_W-1:0] CNT_DATA = CNT_W'(DW);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    num;
  logic [DW-1:0]    dsr;
  logic [DW-1:0]    rem;
  logic [RW-1:0]    quo;
  logic             ovf;

  logic             in_bit;
  logic [DW:0]      rs;
  logic [DW:0]      diff;
  logic             ge;

  // trial subtract; dividend bits then the zero fraction bits
  assign in_bit = (cnt < CNT_DATA) ? num[DW-1] : 1'b0;
  assign rs     = {rem, in_bit};
  assign diff   = rs - {1'b0, dsr};
  assign ge     = (rs >= {1'b0, dsr});

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        cnt <= '0;
        if (start) begin
          busy <= 1'b1;
        end
      end else begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (!busy) begin
      if (start) begin
        num <= dividend;
        dsr <= divisor;
        rem <= '0;
        quo <= '0;
        ovf <= 1'b0;
      end
    end else begin
      num <= num << 1;
      rem <= ge ? diff[DW-1:0] : rs[DW-1:0];
      quo <= {quo[RW-2:0], ge};
      ovf <= ovf | quo[RW-1];
    end
  end

  assign rate = ovf ? wbrm_pkg::RATE_MAX : quo;

endmodule

@@ rtl/windowed_byte_rate_meter_unit.sv @@
// ----------------------------------------------------------------------------
// windowed_byte_rate_meter_unit
// Per-meter byte rate over a minimum time window, bits per millisecond in
// Q32.8, computed with bit-serial arithmetic.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in       | input     | in_valid/in_stall   | in_data   (in_item_t)
//  out      | output    | out_valid/out_stall | out_data  (out_item_t)
//  cfg      | input     | cfg_valid/cfg_ready | cfg_data  (min_interval_ms)
//
//  an in-range item passes two serial passes (subtract and scale, then
//  divide by 100) before the output register, one with a rate also the
//  75-step restoring divider, and an out-of-range item neither of them;
//  one item is in flight at a time; the next is taken while a result waits
//  in the output register
//  synchronous reset clears every meter and loads the window with 2000;
//  no clearing pass is needed
// ----------------------------------------------------------------------------
module windowed_byte_rate_meter_unit #(
  parameter int METER_COUNT = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  wbrm_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output wbrm_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wbrm_pkg::WIN_W-1:0]        cfg_data
);

  localparam int IDX_W = (METER_COUNT > 1) ? $clog2(METER_COUNT) : 1;
  localparam int DW    = wbrm_pkg::DATA_W;
  localparam int CW    = wbrm_pkg::COARSE_W;
  localparam int FW    = wbrm_pkg::FINE_W;
  localparam int WW    = wbrm_pkg::WIN_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_START   = 3'd1;
  localparam logic [2:0] S_ELAPSED = 3'd2;
  localparam logic [2:0] S_DIVIDE  = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;

  logic [2:0]          state;
  logic [WW-1:0]       window;

  // per-meter state
  logic                seen_mem        [METER_COUNT];
  logic [DW-1:0]       last_total_mem  [METER_COUNT];
  logic [CW-1:0]       last_coarse_mem [METER_COUNT];
  logic [FW-1:0]       last_fine_mem   [METER_COUNT];

  // captured item and pending result
  logic [IDX_W-1:0]    sel;
  logic [DW-1:0]       total;
  logic [CW-1:0]       coarse;
  logic [FW-1:0]       fine;
  logic                res_valid;
  logic [wbrm_pkg::RATE_W-1:0] res_rate;

  logic                in_range;
  logic                in_accept;
  logic                out_free;
  logic [WW-1:0]       window_eff;
  logic                too_early;
  logic                seen_cur;
  logic signed [wbrm_pkg::FTERM_W-1:0] fterm;
  logic                ela_start;
  logic                div_start;
  logic                div_done;
  logic [wbrm_pkg::RATE_W-1:0] div_rate;
  logic [DW-1:0]       delta;
  logic [DW-1:0]       ms;
  wbrm_pkg::ela_stat_t ela_stat;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign in_range  = (32'(in_data.meter_select) < METER_COUNT);

  // window check; a zero window acts as one
  assign window_eff = (window == '0) ? WW'(1) : window;
  assign too_early  = (ms[DW-1:WW] == '0) && (ms[WW-1:0] < window_eff);

  assign seen_cur  = seen_mem[sel];
  assign fterm     = wbrm_pkg::fine_term(fine, last_fine_mem[sel]);
  assign ela_start = (state == S_START);
  assign div_start = (state == S_ELAPSED) && ela_stat.done && ela_stat.total_ge
                   && seen_cur && !too_early;

  wbrm_elapsed u_elapsed (
    .clk         (clk),
    .rst         (rst),
    .start       (ela_start),
    .total       (total),
    .last_total  (last_total_mem[sel]),
    .coarse      (coarse),
    .last_coarse (last_coarse_mem[sel]),
    .fterm       (fterm),
    .stat        (ela_stat),
    .delta       (delta),
    .ms          (ms)
  );

  wbrm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (delta),
    .divisor  (ms),
    .done     (div_done),
    .rate     (div_rate)
  );

  // sequencer, meter state and window register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      window    <= wbrm_pkg::WINDOW_RESET;
      out_valid <= 1'b0;
      for (int m = 0; m < METER_COUNT; m++) begin
        seen_mem[m]        <= 1'b0;
        last_total_mem[m]  <= '0;
        last_coarse_mem[m] <= '0;
        last_fine_mem[m]   <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        window <= cfg_data;
      end
      // output register: load a finished item, or empty once taken
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= in_range ? S_START : S_DONE;
          end
        end
        S_START: begin
          state <= S_ELAPSED;
        end
        S_ELAPSED: begin
          if (ela_stat.done) begin
            if (!ela_stat.total_ge || !seen_cur) begin
              // counter reset or first sample: keep it, no rate
              seen_mem[sel]        <= 1'b1 | seen_cur;
              last_total_mem[sel]  <= total;
              last_coarse_mem[sel] <= coarse;
              last_fine_mem[sel]   <= fine;
              state                <= S_DONE;
            end else if (too_early) begin
              state <= S_DONE;
            end else begin
              state <= S_DIVIDE;
            end
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            last_total_mem[sel]  <= total;
            last_coarse_mem[sel] <= coarse;
            last_fine_mem[sel]   <= fine;
            state                <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item capture, pending result and output register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sel       <= IDX_W'(in_data.meter_select);
      total     <= in_data.byte_total;
      coarse    <= in_data.raw_stamp[wbrm_pkg::COARSE_LSB +: CW];
      fine      <= in_data.raw_stamp[FW-1:0];
      res_valid <= 1'b0;
      res_rate  <= '0;
    end else if ((state == S_DIVIDE) && div_done) begin
      res_valid <= 1'b1;
      res_rate  <= div_rate;
    end
    if ((state == S_DONE) && out_free) begin
      out_data.rate_valid <= res_valid;
      out_data.rate_kbps  <= res_rate;
    end
  end

endmodule

@@ rtl/wbrm_checker.sv @@
// ----------------------------------------------------------------------------
// wbrm_checker
// Port-level checks on the byte rate meter, bound to the top level.
// ----------------------------------------------------------------------------
module wbrm_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  wbrm_pkg::out_item_t  out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // no rate means a zero rate field
  a_no_rate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.rate_valid |-> out_data.rate_kbps == '0)
    else $error("rate field set without a rate");

  // one item in flight: accepting stalls the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown straight after reset");

endmodule

bind windowed_byte_rate_meter_unit wbrm_checker u_wbrm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ bench/wbrm_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wbrm_rate_checker
// Watches the sample, result and window channels of the byte rate meter.
// Keeps its own copy of every meter and of the window. For each accepted
// sample it predicts the result, and it compares each accepted result,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module wbrm_rate_checker #(
  parameter int METER_COUNT = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  wbrm_pkg::in_item_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  wbrm_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [wbrm_pkg::WIN_W-1:0] cfg_data,
  output int unsigned                fail_count,
  output int unsigned                pending,
  output int unsigned                results_checked,
  output int unsigned                rates_seen
);

  // shadow of the meters and of the window register
  logic [wbrm_pkg::WIN_W-1:0]    window;
  logic                          seen        [METER_COUNT];
  logic [wbrm_pkg::DATA_W-1:0]   last_total  [METER_COUNT];
  logic [wbrm_pkg::COARSE_W-1:0] last_coarse [METER_COUNT];
  logic [wbrm_pkg::FINE_W-1:0]   last_fine   [METER_COUNT];

  wbrm_pkg::out_item_t expected_rates[$];
  int unsigned errors  = 0;
  int unsigned checked = 0;
  int unsigned rated   = 0;

  // predicted result of one sample; updates the shadow meter as the block would
  function automatic wbrm_pkg::out_item_t advance_meter(wbrm_pkg::in_item_t s);
    int unsigned                   m;
    logic [wbrm_pkg::COARSE_W-1:0] coarse;
    logic [wbrm_pkg::FINE_W-1:0]   fine;
    logic [63:0]                   dtime;
    logic [63:0]                   scaled;
    logic [63:0]                   span_ms;
    logic [63:0]                   eff_win;
    logic signed [15:0]            dfine;
    logic signed [15:0]            fine_adj;
    logic [74:0]                   quot;
    wbrm_pkg::out_item_t           res;
    m       = 32'(s.meter_select);
    coarse  = s.raw_stamp[63:wbrm_pkg::COARSE_LSB];
    fine    = s.raw_stamp[wbrm_pkg::FINE_W-1:0];
    eff_win = (window == '0) ? 64'd1 : 64'(window);
    res     = '0;
    if (m >= METER_COUNT) return res;
    if (last_total[m] <= s.byte_total) begin
      if (!seen[m]) begin
        seen[m] = 1'b1;
      end else begin
        // elapsed milliseconds, wrapping in 64 bits, fine part truncated to zero
        dtime    = 64'(coarse) - 64'(last_coarse[m]);
        dfine    = $signed({10'd0, fine}) - $signed({10'd0, last_fine[m]});
        fine_adj = (dfine * 16'sd125) / 16'sd40;
        scaled   = dtime * 64'd125 + {{48{fine_adj[15]}}, fine_adj};
        span_ms  = scaled / 64'd100;
        // too early: the meter keeps its stored sample
        if (span_ms < eff_win) return res;
        quot = {s.byte_total - last_total[m], 11'd0} / {11'd0, span_ms};
        res.rate_valid = 1'b1;
        res.rate_kbps  = (quot > 75'(wbrm_pkg::RATE_MAX)) ? wbrm_pkg::RATE_MAX
                                                          : quot[wbrm_pkg::RATE_W-1:0];
      end
    end
    // first sample, counter reset or a reported rate: store the sample
    last_total[m]  = s.byte_total;
    last_coarse[m] = coarse;
    last_fine[m]   = fine;
    return res;
  endfunction

  // track the channels, compare results in order
  always @(posedge clk) begin
    wbrm_pkg::out_item_t want;
    if (rst) begin
      window = wbrm_pkg::WINDOW_RESET;
      for (int i = 0; i < METER_COUNT; i++) begin
        seen[i]        = 1'b0;
        last_total[i]  = '0;
        last_coarse[i] = '0;
        last_fine[i]   = '0;
      end
      expected_rates.delete();
    end else begin
      if (cfg_valid && cfg_ready) window = cfg_data;
      if (in_valid && !in_stall) expected_rates.push_back(advance_meter(in_data));
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_rates.size() == 0) begin
          errors++;
          $error("result transaction with no sample pending: rate_valid %0d rate_kbps %0d",
                 out_data.rate_valid, out_data.rate_kbps);
        end else begin
          want = expected_rates.pop_front();
          if (want.rate_valid) rated++;
          if (out_data.rate_valid !== want.rate_valid) begin
            errors++;
            $error("rate_valid: expected %0d, got %0d", want.rate_valid, out_data.rate_valid);
          end
          if (out_data.rate_kbps !== want.rate_kbps) begin
            errors++;
            $error("rate_kbps: expected %0d, got %0d", want.rate_kbps, out_data.rate_kbps);
          end
        end
      end
    end
    fail_count      <= errors;
    pending         <= expected_rates.size();
    results_checked <= checked;
    rates_seen      <= rated;
  end

endmodule

@@ bench/windowed_byte_rate_meter_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_byte_rate_meter_unit_tb
// Drives samples into the byte rate meter: a directed set covering the
// window edge, fine-time correction both ways, saturation, counter resets
// and time wrap, then random sample streams per meter under several window
// settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module windowed_byte_rate_meter_unit_tb;

  localparam int METERS       = 2;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASES       = 6;
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 2_000_000;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  wbrm_pkg::in_item_t         in_data   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  wbrm_pkg::out_item_t        out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [wbrm_pkg::WIN_W-1:0] cfg_data  = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_checked;
  int unsigned rates_seen;

  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_pct   = 0;
  int unsigned burst_left  = 0;
  int unsigned gap_max     = 0;
  int unsigned samples_sent = 0;
  int unsigned windows_used = 0;

  // what was last sent per meter, used to shape well-formed streams
  logic [wbrm_pkg::WIN_W-1:0]    win_cur = wbrm_pkg::WINDOW_RESET;
  logic [wbrm_pkg::DATA_W-1:0]   sent_total  [METERS] = '{default: '0};
  logic [wbrm_pkg::COARSE_W-1:0] sent_coarse [METERS] = '{default: '0};

  logic [wbrm_pkg::WIN_W-1:0] phase_win [PHASES] =
    '{16'd1, 16'd65535, 16'd0, 16'd2000, 16'd37, 16'd500};

  windowed_byte_rate_meter_unit #(.METER_COUNT(METERS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  wbrm_rate_checker #(.METER_COUNT(METERS)) rate_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .rates_seen      (rates_seen)
  );

  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: stall runs, with the stall density changing now and then
  always @(posedge clk) begin
    if (cycle_count % 4096 == 0) begin
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 35;
        default: stall_pct = 80;
      endcase
    end
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      out_stall  <= ($urandom_range(0, 99) < stall_pct);
      stall_left <= $urandom_range(0, 15);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // build a sample with the ignored stamp bits clear
  function automatic wbrm_pkg::in_item_t sample(logic m, logic [wbrm_pkg::DATA_W-1:0] total,
                                                logic [wbrm_pkg::COARSE_W-1:0] coarse,
                                                logic [wbrm_pkg::FINE_W-1:0] fine);
    wbrm_pkg::in_item_t t;
    t.meter_select = m;
    t.byte_total   = total;
    t.raw_stamp    = {coarse, 10'd0, fine};
    sent_total[m]  = total;
    sent_coarse[m] = coarse;
    return t;
  endfunction

  // mostly advancing streams around the window, some counter resets and noise
  function automatic wbrm_pkg::in_item_t random_sample();
    wbrm_pkg::in_item_t            t;
    logic                          m;
    int unsigned                   pick;
    int unsigned                   tw;
    logic [wbrm_pkg::DATA_W-1:0]   total;
    logic [wbrm_pkg::DATA_W-1:0]   step_bytes;
    logic [wbrm_pkg::COARSE_W-1:0] ticks;
    m  = 1'($urandom_range(0, METERS - 1));
    tw = (int'(win_cur) * 4) / 5 + 1;
    pick = $urandom_range(0, 99);
    if (pick < 20)      ticks = 48'($urandom_range(0, tw));
    else if (pick < 40) ticks = 48'(tw - 1 + $urandom_range(0, 2));
    else if (pick < 92) ticks = 48'($urandom_range(tw, 3 * tw + 8));
    else                ticks = {16'($urandom), 32'($urandom)};
    pick = $urandom_range(0, 99);
    if (pick < 30)      step_bytes = 64'($urandom_range(0, 5000));
    else if (pick < 70) step_bytes = 64'($urandom);
    else if (pick < 92) step_bytes = {22'd0, 10'($urandom), 32'($urandom)};
    else                step_bytes = {32'($urandom), 32'($urandom)};
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // noise
      t = sample(m, {32'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                 6'($urandom));
    end else if (pick < 16) begin
      // counter reset
      total = sent_total[m] >> $urandom_range(0, 63);
      t = sample(m, total, sent_coarse[m] + ticks, 6'($urandom));
    end else begin
      t = sample(m, sent_total[m] + step_bytes, sent_coarse[m] + ticks, 6'($urandom));
    end
    t.raw_stamp[15:6] = 10'($urandom);
    return t;
  endfunction

  // one input transaction, in bursts with random gaps
  task automatic send_sample(input wbrm_pkg::in_item_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_window(input logic [wbrm_pkg::WIN_W-1:0] w);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    win_cur = w;
    windows_used++;
  endtask

  initial begin
    wbrm_pkg::in_item_t t;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed, window at its reset value of 2000
    gap_max = 3;
    send_sample(sample(1'b0, 64'd0, 48'd0, 6'd0));             // first sample
    send_sample(sample(1'b0, 64'd100, 48'd100, 6'd0));         // too early
    send_sample(sample(1'b0, 64'd1000, 48'd1600, 6'd0));       // exactly the window
    send_sample(sample(1'b0, 64'd1000, 48'd3199, 6'd63));      // no bytes, fine +63
    send_sample(sample(1'b0, '1, 48'd4800, 6'd0));             // fine -63 drops below
    send_sample(sample(1'b0, '1, 48'd4899, 6'd0));             // saturated rate
    send_sample(sample(1'b0, 64'd5, 48'd6899, 6'd7));          // counter reset
    send_sample(sample(1'b0, 64'd10, 48'd6899, 6'd0));         // negative sum wraps
    send_sample(sample(1'b1, 64'd0, '1, 6'd63));               // uplink first sample
    send_sample(sample(1'b1, 64'd12345, 48'h63F, 6'd0));       // time runs backwards
    send_sample(sample(1'b1, 64'h8000_0000_0000_0000, 48'h8000_0000_063F, 6'd0));
    send_sample(sample(1'b1, 64'h8000_0000_0001_0000, 48'h8000_0000_0C7F, 6'd0));
    send_sample(sample(1'b1, 64'h8000_0000_0001_0000, 48'h8000_0000_0C7F, 6'd0));
    t = sample(1'b0, '1, '1, '1);
    t.raw_stamp = '1;
    send_sample(t);                                            // every bit set
    send_sample(sample(1'b0, 64'd0, 48'd0, 6'd0));             // reset to zero

    // random streams under each window setting
    phase_win[4] = 16'($urandom_range(1, 65535));
    for (int p = 0; p < PHASES; p++) begin
      write_window(phase_win[p]);
      gap_max = (p % 3 == 1) ? 0 : $urandom_range(1, 10);
      repeat (RANDOM_ITEMS / PHASES) send_sample(random_sample());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d samples over %0d window writes plus the reset window",
             samples_sent, windows_used);
    $display("checked %0d results, %0d of them carrying a rate", results_checked, rates_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
